>>> hdl/acd_pkg.sv
`timescale 1ns / 1ps
package acd_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int SINE_DEPTH = 1024;
  localparam int IDX_W     = 10;
  localparam int CAR_SHIFT = 10;
  localparam int DC_SHIFT  = 11;
  localparam int GAIN_W    = 31;
  localparam int FLOOR_W   = 16;
  localparam int CAR_W     = 32;
  localparam int DC_W      = SAMPLE_W + DC_SHIFT + 2;
  localparam int DEMOD_W   = SAMPLE_W + 2;
  localparam int INTEG_W   = 33;
  localparam int QUO_BITS  = SAMPLE_W;
  localparam int QUO_W     = SAMPLE_W + 1;
  localparam int DIV_W     = CAR_W + 3;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1073741824;
  localparam longint unsigned TaylorDiv [6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

  // register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_ENABLE    = 2'd0,
    REG_PROP_GAIN = 2'd1,
    REG_INTEG_GAIN = 2'd2,
    REG_FLOOR     = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ROM, ST_MUL, ST_ERR, ST_GI, ST_GP, ST_UPD, ST_CHK, ST_DIV, ST_FIN, ST_OUT
  } core_state_t;

  typedef struct packed {
    logic                 enable;
    logic [GAIN_W-1:0]    prop_gain;
    logic [GAIN_W-1:0]    integ_gain;
    logic [FLOOR_W-1:0]   carrier_floor;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] in_i;
    logic signed [SAMPLE_W-1:0] in_q;
  } sample_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] audio;
    logic                       carrier_low;
    logic [15:0]                carrier_out;
  } result_t;

  typedef struct packed {
    logic empty;
    logic pop;
  } fifo_ctl_t;

  typedef logic signed [SAMPLE_W-1:0] sine_tbl_t [SINE_DEPTH];

  // Taylor series of sin over a quarter turn in Q30, rounded to Q1.15
  function automatic sine_tbl_t build_sine();
    sine_tbl_t       t;
    longint unsigned f;
    longint unsigned r;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned mag;
    longint unsigned v;
    longint          sum;
    longint unsigned quad;
    for (int k = 0; k < SINE_DEPTH; k++) begin
      f = (longint'(k) << 32) / SINE_DEPTH;
      quad = (f >> 30) & 64'd3;
      r = f & 64'h3FFF_FFFF;
      if (quad[0]) r = ONE_Q30 - r;
      x = (r * HALF_PI_Q30) >> 30;
      x2 = (x * x) >> 30;
      mag = x;
      sum = longint'(x);
      for (int n = 1; n <= 6; n++) begin
        mag = (mag * x2) >> 30;
        mag = mag / TaylorDiv[n-1];
        if (n % 2 == 1) sum = sum - longint'(mag);
        else sum = sum + longint'(mag);
      end
      if (sum < 0) sum = 0;
      if (sum > longint'(ONE_Q30)) sum = longint'(ONE_Q30);
      v = (longint'(sum) * 64'd32767 + 64'd536870912) >> 30;
      t[k] = (quad >= 2) ? SAMPLE_W'(-longint'(v)) : SAMPLE_W'(v);
    end
    return t;
  endfunction

endpackage

>>> hdl/acd_fifo.sv
`timescale 1ns / 1ps
module acd_fifo
  import acd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  sample_t   wdata,
  output logic      full,
  input  fifo_ctl_t ctl_in,
  output fifo_ctl_t ctl_out,
  output sample_t   rdata
);

  sample_t    mem_r [2];
  logic       wptr_r;
  logic       rptr_r;
  logic [1:0] cnt_r;
  logic       do_push;
  logic       do_pop;

  assign full          = (cnt_r == 2'd2);
  assign ctl_out.empty = (cnt_r == 2'd0);
  assign ctl_out.pop   = do_pop;
  assign do_push       = push && !full;
  assign do_pop        = ctl_in.pop && (cnt_r != 2'd0);
  assign rdata         = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (do_push) wptr_r <= !wptr_r;
      if (do_pop) rptr_r <= !rptr_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= wdata;
  end

endmodule

>>> hdl/acd_core.sv
`timescale 1ns / 1ps
module acd_core
  import acd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  fifo_ctl_t q_stat,
  output fifo_ctl_t q_req,
  input  sample_t   smp,
  output logic      res_valid,
  input  logic      res_ready,
  output result_t   res
);

  localparam sine_tbl_t SINE_TBL = build_sine();
  localparam logic [IDX_W-1:0] QUARTER = IDX_W'(SINE_DEPTH / 4);
  localparam logic signed [DC_W+1:0] DC_LIM = (DC_W+2)'(longint'(1) << (SAMPLE_W + DC_SHIFT));
  localparam logic signed [INTEG_W+2:0] INT_MAX = (INTEG_W+3)'((longint'(1) << 32) - 1);
  localparam logic signed [INTEG_W+2:0] INT_MIN = (INTEG_W+3)'(-(longint'(1) << 32));

  core_state_t state_r, state_nxt;

  logic signed [SAMPLE_W-1:0]  re_r, im_r, sin_r, cos_r;
  logic signed [32:0]          acc_i_r, acc_q_r;
  logic [1:0]                  mcnt_r;
  logic signed [DEMOD_W-1:0]   id_r, err_r;
  logic signed [GAIN_W+DEMOD_W:0] gprod_r;
  logic signed [INTEG_W-1:0]   integ_r;
  logic [31:0]                 phase_r;
  logic [CAR_W-1:0]            car_r;
  logic signed [DC_W-1:0]      dc_r;
  logic [DIV_W-1:0]            rem_r, den_r;
  logic [QUO_W-1:0]            quo_r;
  logic [3:0]                  dcnt_r;
  logic                        neg_r;
  result_t                     res_r;

  logic [IDX_W-1:0]            sidx;
  logic signed [SAMPLE_W-1:0]  mul_a, mul_b;
  logic signed [2*SAMPLE_W-1:0] prod;
  logic signed [DEMOD_W-1:0]   qd;
  logic signed [GAIN_W:0]      gain_s;
  logic signed [INTEG_W+2:0]   integ_sum, freq;
  logic [DEMOD_W-1:0]          mag;
  logic signed [DC_W+1:0]      dc_sum;
  logic signed [DEMOD_W-1:0]   dc_int;
  logic signed [DEMOD_W+1:0]   a_val;
  logic [DEMOD_W+1:0]          a_mag;
  logic [DIV_W-1:0]            den, num0, rem2;
  logic [CAR_W-CAR_SHIFT-1:0]  level;
  logic                        low;
  logic [15:0]                 car_sat;

  assign sidx  = phase_r[31 -: IDX_W];
  assign level = car_r[CAR_W-1:CAR_SHIFT];
  assign low   = (car_r == '0) || (level < (CAR_W-CAR_SHIFT)'(cfg.carrier_floor));
  assign car_sat = (level > (CAR_W-CAR_SHIFT)'(16'hFFFF)) ? 16'hFFFF : level[15:0];

  // quarter-turn offset gives cosine from the same table
  always_ff @(posedge clk) begin
    sin_r <= SINE_TBL[sidx];
    cos_r <= SINE_TBL[sidx + QUARTER];
  end

  always_comb begin
    case (mcnt_r)
      2'd0:    begin mul_a = re_r; mul_b = cos_r; end
      2'd1:    begin mul_a = im_r; mul_b = sin_r; end
      2'd2:    begin mul_a = im_r; mul_b = cos_r; end
      default: begin mul_a = re_r; mul_b = sin_r; end
    endcase
    prod   = mul_a * mul_b;
    qd     = acc_q_r[32:15];
    gain_s = (state_r == ST_GI) ? $signed({1'b0, cfg.integ_gain})
                                : $signed({1'b0, cfg.prop_gain});
    integ_sum = (INTEG_W+3)'(integ_r) + (INTEG_W+3)'(gprod_r >>> 15);
    freq      = (INTEG_W+3)'(integ_r) + (INTEG_W+3)'(gprod_r >>> 15);
    mag       = id_r[DEMOD_W-1] ? DEMOD_W'(-id_r) : DEMOD_W'(id_r);
    dc_sum    = (DC_W+2)'(dc_r) - (DC_W+2)'(dc_r >>> DC_SHIFT) + (DC_W+2)'(id_r);
    dc_int    = DEMOD_W'(dc_r >>> DC_SHIFT);
    a_val     = (DEMOD_W+2)'(id_r) - (DEMOD_W+2)'(dc_int);
    a_mag     = a_val[DEMOD_W+1] ? (DEMOD_W+2)'(-a_val) : (DEMOD_W+2)'(a_val);
    den       = DIV_W'(car_r) + DIV_W'({car_r, 1'b0});
    num0      = DIV_W'({a_mag, {CAR_SHIFT{1'b0}}});
    rem2      = {rem_r[DIV_W-2:0], 1'b0};
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (!q_stat.empty) state_nxt = cfg.enable ? ST_ROM : ST_OUT;
      ST_ROM:  state_nxt = ST_MUL;
      ST_MUL:  if (mcnt_r == 2'd3) state_nxt = ST_ERR;
      ST_ERR:  state_nxt = ST_GI;
      ST_GI:   state_nxt = ST_GP;
      ST_GP:   state_nxt = ST_UPD;
      ST_UPD:  state_nxt = ST_CHK;
      ST_CHK:  state_nxt = (low || num0 >= den) ? ST_FIN : ST_DIV;
      ST_DIV:  if (dcnt_r == 4'(QUO_BITS - 1)) state_nxt = ST_FIN;
      ST_FIN:  state_nxt = ST_OUT;
      ST_OUT:  if (res_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_req.empty = q_stat.empty;
    q_req.pop   = (state_r == ST_IDLE) && !q_stat.empty;
    res_valid   = (state_r == ST_OUT);
    res         = res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= '0;
      integ_r <= '0;
      car_r   <= '0;
      dc_r    <= '0;
      mcnt_r  <= '0;
      dcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_MUL: mcnt_r <= mcnt_r + 2'd1;
        ST_GP: begin
          if (integ_sum > INT_MAX) integ_r <= INTEG_W'(INT_MAX);
          else if (integ_sum < INT_MIN) integ_r <= INTEG_W'(INT_MIN);
          else integ_r <= INTEG_W'(integ_sum);
        end
        ST_UPD: begin
          phase_r <= phase_r + freq[31:0];
          car_r   <= car_r - (car_r >> CAR_SHIFT) + CAR_W'(mag);
          if (dc_sum > DC_LIM - 1) dc_r <= DC_W'(DC_LIM - 1);
          else if (dc_sum < -DC_LIM) dc_r <= DC_W'(-DC_LIM);
          else dc_r <= DC_W'(dc_sum);
        end
        ST_CHK: dcnt_r <= '0;
        ST_DIV: dcnt_r <= dcnt_r + 4'd1;
        default: ;
      endcase
    end
  end

  // payload path
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        re_r <= smp.in_i;
        im_r <= smp.in_q;
        res_r.audio       <= '0;
        res_r.carrier_low <= low;
        res_r.carrier_out <= car_sat;
      end
      ST_MUL: begin
        case (mcnt_r)
          2'd0:    acc_i_r <= 33'(prod);
          2'd1:    acc_i_r <= acc_i_r + 33'(prod);
          2'd2:    acc_q_r <= 33'(prod);
          default: acc_q_r <= acc_q_r - 33'(prod);
        endcase
      end
      ST_ERR: begin
        id_r  <= acc_i_r[32:15];
        err_r <= acc_i_r[32] ? -qd : qd;
      end
      ST_GI, ST_GP: gprod_r <= gain_s * err_r;
      ST_CHK: begin
        neg_r <= a_val[DEMOD_W+1];
        den_r <= den;
        rem_r <= num0;
        quo_r <= (num0 >= den) ? QUO_W'(1 << QUO_BITS) : '0;
        res_r.carrier_low <= low;
        res_r.carrier_out <= car_sat;
      end
      ST_DIV: begin
        if (rem2 >= den_r) begin
          rem_r <= rem2 - den_r;
          quo_r <= {quo_r[QUO_W-2:0], 1'b1};
        end else begin
          rem_r <= rem2;
          quo_r <= {quo_r[QUO_W-2:0], 1'b0};
        end
      end
      ST_FIN: begin
        if (res_r.carrier_low) res_r.audio <= '0;
        else if (neg_r)
          res_r.audio <= (quo_r > QUO_W'(1 << (SAMPLE_W-1))) ? SAMPLE_W'(1 << (SAMPLE_W-1))
                                                            : SAMPLE_W'(-quo_r);
        else
          res_r.audio <= (quo_r > QUO_W'((1 << (SAMPLE_W-1)) - 1))
                         ? SAMPLE_W'((1 << (SAMPLE_W-1)) - 1) : SAMPLE_W'(quo_r);
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_req.pop |-> !q_stat.empty) else $error("pop from empty queue");
  a_low_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.carrier_low |-> res.audio == '0) else $error("audio while carrier low");
  a_dc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (dc_r <= DC_W'(DC_LIM - 1)) && (dc_r >= DC_W'(-DC_LIM))) else $error("dc out of range");
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_OUT && !res_ready |=> $stable(phase_r) && $stable(car_r))
    else $error("loop state moved while result waits");
`endif

endmodule

>>> hdl/coherent_am_costas_demodulator.sv
`timescale 1ns / 1ps
// Coherent AM demodulator with a Costas carrier loop. Samples (Q1.15 I/Q) enter a two-beat
// queue; a sequencer behind it mixes each beat with a 1024-entry sine/cosine NCO, runs the
// PI loop filter, updates carrier and DC averages and divides (I - DC) by 1.5x carrier with
// a restoring divider of one quotient bit per cycle. A sample while disabled skips the
// mixer, loop and divider; one below the carrier floor skips only the divider. One result
// beat can wait on the output register while the next sample is queued. Configure only
// while idle; registers: enable, prop_gain, integ_gain, carrier_floor (reset 1).
module coherent_am_costas_demodulator
  import acd_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [GAIN_W-1:0]          cfg_wdata,
  input  logic                       push,
  output logic                       full,
  input  logic signed [SAMPLE_W-1:0] in_i,
  input  logic signed [SAMPLE_W-1:0] in_q,
  output logic                       empty,
  input  logic                       pop,
  output logic signed [SAMPLE_W-1:0] out_audio,
  output logic                       out_carrier_low,
  output logic [15:0]                out_carrier_out
);

  cfg_t      cfg_r;
  sample_t   wdata;
  sample_t   rdata;
  fifo_ctl_t q_stat;
  fifo_ctl_t q_req;
  logic      res_valid;
  logic      res_ready;
  result_t   res;
  logic      out_valid_r;
  result_t   out_r;

  // hold configuration; out-of-range indexes cannot occur on a 2-bit index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable        <= 1'b0;
      cfg_r.prop_gain     <= '0;
      cfg_r.integ_gain    <= '0;
      cfg_r.carrier_floor <= FLOOR_W'(1);
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ENABLE:     cfg_r.enable        <= cfg_wdata[0];
        REG_PROP_GAIN:  cfg_r.prop_gain     <= cfg_wdata;
        REG_INTEG_GAIN: cfg_r.integ_gain    <= cfg_wdata;
        REG_FLOOR:      cfg_r.carrier_floor <= cfg_wdata[FLOOR_W-1:0];
        default: ;
      endcase
    end
  end

  assign wdata.in_i = in_i;
  assign wdata.in_q = in_q;

  // front: sample queue
  acd_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wdata   (wdata),
    .full    (full),
    .ctl_in  (q_req),
    .ctl_out (q_stat),
    .rdata   (rdata)
  );

  // back: loop and divider sequencer
  acd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_stat    (q_stat),
    .q_req     (q_req),
    .smp       (rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // result register: advance when empty or being drained
  assign res_ready = !out_valid_r || pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) out_r <= res;
  end

  assign empty           = !out_valid_r;
  assign out_audio       = out_r.audio;
  assign out_carrier_low = out_r.carrier_low;
  assign out_carrier_out = out_r.carrier_out;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import acd_pkg::*;

  // clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #6 clk = ~clk;

  // block ports, inputs all known from time zero
  logic                       cfg_we = 1'b0;
  logic [1:0]                 cfg_index = 2'd0;
  logic [GAIN_W-1:0]          cfg_wdata = '0;
  logic                       push = 1'b0;
  logic                       full;
  logic signed [SAMPLE_W-1:0] in_i = '0;
  logic signed [SAMPLE_W-1:0] in_q = '0;
  logic                       empty;
  logic                       pop = 1'b0;
  logic signed [SAMPLE_W-1:0] out_audio;
  logic                       out_carrier_low;
  logic [15:0]                out_carrier_out;

  coherent_am_costas_demodulator dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .push(push), .full(full), .in_i(in_i), .in_q(in_q),
    .empty(empty), .pop(pop),
    .out_audio(out_audio), .out_carrier_low(out_carrier_low),
    .out_carrier_out(out_carrier_out)
  );

  // samples waiting to go in, and demodulated beats still owed by the block
  sample_t pending_samples[$];
  result_t expected_audio[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int samples_in = 0;
  int beats_out = 0;
  int audible_beats = 0;

  // shadow of the demodulator: registers and loop state
  logic                 sh_enable = 1'b0;
  logic [GAIN_W-1:0]    sh_prop = '0;
  logic [GAIN_W-1:0]    sh_integ = '0;
  logic [FLOOR_W-1:0]   sh_floor = 16'd1;
  logic [31:0]          sh_phase = '0;
  longint               sh_integrator = 0;
  longint               sh_dc = 0;
  longint unsigned      sh_carrier = 0;
  logic signed [15:0]   sine_rom [SINE_DEPTH];

  // build the NCO table: Taylor series of sin over a quarter turn in Q30
  initial begin
    longint unsigned frac, rem, x, x2, term, v, quad;
    longint acc;
    for (int k = 0; k < SINE_DEPTH; k++) begin
      frac = longint'(k) << 22;
      quad = frac >> 30;
      rem = frac & 64'h3FFF_FFFF;
      if (quad[0]) rem = ONE_Q30 - rem;
      x = (rem * HALF_PI_Q30) >> 30;
      x2 = (x * x) >> 30;
      term = x;
      acc = longint'(x);
      for (int n = 1; n <= 6; n++) begin
        term = (term * x2) >> 30;
        term = term / longint'((2 * n) * (2 * n + 1));
        if (n % 2) acc -= longint'(term);
        else acc += longint'(term);
      end
      if (acc < 0) acc = 0;
      if (acc > longint'(ONE_Q30)) acc = longint'(ONE_Q30);
      v = (longint'(acc) * 64'd32767 + 64'd536870912) >> 30;
      sine_rom[k] = (quad >= 2) ? 16'(-longint'(v)) : 16'(v);
    end
  end

  // advance the shadow loop by one sample and return the beat it yields
  function automatic result_t demod_sample(logic signed [15:0] si, logic signed [15:0] sq);
    longint re, im, s, c, id, qd, err, freq, a;
    longint unsigned lvl, am, num, den, quo, rmd;
    logic [31:0] cos_ph;
    logic low;
    result_t res;
    re = si;
    im = sq;
    a = 0;
    res.audio = '0;
    if (sh_enable) begin
      cos_ph = sh_phase + 32'h4000_0000;
      s = sine_rom[sh_phase[31:22]];
      c = sine_rom[cos_ph[31:22]];
      id = (re * c + im * s) >>> 15;
      qd = (im * c - re * s) >>> 15;
      err = (id >= 0) ? qd : -qd;
      sh_integrator += (longint'(sh_integ) * err) >>> 15;
      if (sh_integrator > 64'sd4294967295) sh_integrator = 64'sd4294967295;
      if (sh_integrator < -64'sd4294967296) sh_integrator = -64'sd4294967296;
      freq = sh_integrator + ((longint'(sh_prop) * err) >>> 15);
      sh_phase = sh_phase + freq[31:0];
      sh_carrier = sh_carrier - (sh_carrier >> CAR_SHIFT) + longint'(id < 0 ? -id : id);
      sh_dc = sh_dc - (sh_dc >>> DC_SHIFT) + id;
      if (sh_dc > (64'sd1 <<< 27) - 1) sh_dc = (64'sd1 <<< 27) - 1;
      if (sh_dc < -(64'sd1 <<< 27)) sh_dc = -(64'sd1 <<< 27);
      a = id - (sh_dc >>> DC_SHIFT);
    end
    lvl = sh_carrier >> CAR_SHIFT;
    low = (sh_carrier == 0) || (lvl < sh_floor);
    if (sh_enable && !low) begin
      // long division of |I - DC| * 2^26 by 3 * carrier, stopping once it saturates
      am = (a < 0) ? -a : a;
      num = am << SAMPLE_W;
      den = 3 * sh_carrier;
      quo = num / den;
      rmd = num % den;
      for (int b = 0; b < CAR_SHIFT && quo < 65536; b++) begin
        rmd <<= 1;
        quo <<= 1;
        if (rmd >= den) begin
          rmd -= den;
          quo |= 1;
        end
      end
      if (quo > 65536) quo = 65536;
      if (a < 0) res.audio = (quo > 32768) ? -16'sd32768 : 16'(-longint'(quo));
      else res.audio = (quo > 32767) ? 16'sd32767 : 16'(quo);
    end
    res.carrier_low = low;
    res.carrier_out = (lvl > 65535) ? 16'hFFFF : lvl[15:0];
    return res;
  endfunction

  // driver: retire the accepted beat into the shadow, then offer the next sample
  always @(posedge clk) begin
    if (rst_n) begin
      if (push && !full) begin
        expected_audio.push_back(demod_sample(in_i, in_q));
        void'(pending_samples.pop_front());
        samples_in++;
      end
      if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        push <= 1'b1;
        in_i <= pending_samples[0].in_i;
        in_q <= pending_samples[0].in_q;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // monitor: check each popped beat against the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (rst_n) begin
      if (pop && !empty) begin
        beats_out++;
        if (expected_audio.size() == 0) begin
          $error("unexpected beat: audio %0d carrier_low %0b carrier_out %0d",
                 out_audio, out_carrier_low, out_carrier_out);
          mismatches++;
        end else begin
          want = expected_audio.pop_front();
          if (!want.carrier_low) audible_beats++;
          if (out_audio !== want.audio) begin
            $error("audio: expected %0d got %0d", want.audio, out_audio);
            mismatches++;
          end
          if (out_carrier_low !== want.carrier_low) begin
            $error("carrier_low: expected %0b got %0b", want.carrier_low, out_carrier_low);
            mismatches++;
          end
          if (out_carrier_out !== want.carrier_out) begin
            $error("carrier_out: expected %0d got %0d", want.carrier_out, out_carrier_out);
            mismatches++;
          end
        end
      end
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // write one register and mirror it in the shadow
  task automatic write_reg(reg_idx_t idx, logic [GAIN_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ENABLE:     sh_enable = val[0];
      REG_PROP_GAIN:  sh_prop = val;
      REG_INTEG_GAIN: sh_integ = val;
      REG_FLOOR:      sh_floor = val[FLOOR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic setup(logic en, logic [GAIN_W-1:0] kp, logic [GAIN_W-1:0] ki,
                       logic [FLOOR_W-1:0] flr);
    write_reg(REG_ENABLE, GAIN_W'(en));
    write_reg(REG_PROP_GAIN, kp);
    write_reg(REG_INTEG_GAIN, ki);
    write_reg(REG_FLOOR, GAIN_W'(flr));
  endtask

  task automatic queue_sample(int si, int sq);
    sample_t smp;
    smp.in_i = 16'(si);
    smp.in_q = 16'(sq);
    pending_samples.push_back(smp);
  endtask

  // mostly a steady carrier with light noise; some beats fully random
  task automatic queue_random(int count);
    int amp;
    amp = $urandom_range(30000, 1000);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 5) amp = $urandom_range(32000, 200);
      if ($urandom_range(99) < 65)
        queue_sample(amp + $urandom_range(3000) - 1500, $urandom_range(4000) - 2000);
      else
        queue_sample($urandom_range(65535), $urandom_range(65535));
    end
  endtask

  // hold until every sample is in and every beat is out, then let the sequencer settle
  task automatic drain();
    while (pending_samples.size() > 0 || push || expected_audio.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // disabled after reset: audio zero, carrier reported low
    queue_sample(-32768, -32768);
    queue_sample(32767, 32767);
    queue_sample(0, 0);
    queue_sample(-32768, 32767);
    drain();

    // floor zero with an empty carrier must still read as low; then extremes
    setup(1'b1, '0, '0, 16'd0);
    queue_sample(0, 0);
    queue_sample(32767, 0);
    queue_sample(-32768, 0);
    queue_sample(32767, 32767);
    queue_sample(-32768, -32768);
    queue_sample(0, -32768);
    queue_sample(0, 32767);
    queue_sample(-32768, 32767);
    queue_sample(32767, -32768);
    queue_sample(1, -1);
    queue_sample(-1, 1);
    queue_sample(20000, 300);
    drain();

    setup(1'b1, GAIN_W'($urandom_range(1 << 20)), GAIN_W'($urandom_range(1 << 12)), 16'd1);
    queue_random(140);
    drain();

    send_idle_pct = 79;
    setup(1'b1, {GAIN_W{1'b1}}, {GAIN_W{1'b1}}, 16'd0);
    queue_random(130);
    drain();

    send_idle_pct = 0;
    recv_stall_pct = 79;
    setup(1'b1, GAIN_W'($urandom), GAIN_W'($urandom_range(1 << 16)),
          16'($urandom_range(40)));
    queue_random(130);
    drain();

    send_idle_pct = 24;
    recv_stall_pct = 24;
    setup(1'b1, GAIN_W'($urandom), GAIN_W'($urandom), 16'hFFFF);
    queue_random(100);
    drain();

    // disabled again: state must hold while beats keep flowing
    send_idle_pct = 0;
    recv_stall_pct = 0;
    setup(1'b0, GAIN_W'($urandom_range(1 << 18)), '0, 16'd2);
    queue_random(60);
    drain();

    send_idle_pct = 24;
    recv_stall_pct = 24;
    write_reg(REG_ENABLE, GAIN_W'(1));
    queue_random(130);
    drain();

    $display("covered %0d samples and %0d beats, %0d of them above the carrier floor",
             samples_in, beats_out, audible_beats);
    $display("sweeps: disabled, zero/max gains, floors 0 to 65535, sender and receiver stalls");
    if (mismatches == 0) begin
      $display("coherent_am_costas_demodulator regression: pass");
    end else begin
      $display("coherent_am_costas_demodulator regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("coherent_am_costas_demodulator regression: fail");
    $finish;
  end

endmodule
